>>> src/uart_transmitter_with_fifo_core_macros.svh
// Assertion macros shared by the UART transmitter RTL.
// Assumes the including module has clk and arst_n in scope.
`ifndef UART_TRANSMITTER_WITH_FIFO_CORE_MACROS_SVH
`define UART_TRANSMITTER_WITH_FIFO_CORE_MACROS_SVH
`ifndef SYNTH
`define UTX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define UTX_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define UTX_ASSERT(lbl, prop, msg)
`define UTX_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/uarttx_pkg.sv
// Types, constants and helper functions for the UART transmitter.
// No dependencies; used by every module of the block.
package uarttx_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int IDX_W      = $clog2(FIFO_DEPTH);
	localparam int PTR_MOD    = 2 * FIFO_DEPTH;
	localparam int PTR_W      = $clog2(PTR_MOD);

	localparam logic [9:0] SHIFT_IDLE = 10'h3FF;
	localparam logic [3:0] END_PARITY = 4'hA;
	localparam logic [3:0] END_PLAIN  = 4'h9;

	typedef enum logic [1:0] {
		CFG_ENABLE        = 2'd0,
		CFG_PARITY_FRAME  = 2'd1,
		CFG_PARITY_INVERT = 2'd2,
		CFG_LEVEL_SELECT  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		LVL_EMPTY = 2'd0,
		LVL_TWO   = 2'd1,
		LVL_FOUR  = 2'd2,
		LVL_EIGHT = 2'd3
	} level_sel_t;

	typedef struct packed {
		logic       baud_tick;
		logic       write_valid;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic       tx_line;
		logic       busy_res;
		logic       not_full;
		logic       level_reached;
		logic [4:0] queued_count;
	} out_item_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] v;
		v = (p >= PTR_W'(FIFO_DEPTH)) ? p - PTR_W'(FIFO_DEPTH) : p;
		return v[IDX_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] fill_level(input logic [PTR_W-1:0] w,
			input logic [PTR_W-1:0] r);
		logic [PTR_W:0] d;
		if (w >= r) begin
			d = {1'b0, w} - {1'b0, r};
		end else begin
			d = {1'b0, w} + (PTR_W+1)'(PTR_MOD) - {1'b0, r};
		end
		return d[PTR_W-1:0];
	endfunction

	function automatic logic level_hit(input level_sel_t sel, input logic [PTR_W-1:0] n);
		logic hit;
		unique case (sel)
			LVL_EMPTY: hit = (n == '0);
			LVL_TWO:   hit = (n <= PTR_W'(2));
			LVL_FOUR:  hit = (n <= PTR_W'(4));
			LVL_EIGHT: hit = (n <= PTR_W'(8));
			default:   hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

>>> src/uarttx_ram.sv
// Transmit byte store: one write port, one registered read port, write-first.
// Depends on uarttx_pkg for depth and index width.
module uarttx_ram
	import uarttx_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem [FIFO_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// same-entry write forwards so the head is valid the following cycle
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/uarttx_skid.sv
// Output register with one skid entry for the result channel.
// Depends on uarttx_pkg for the result struct.
`include "uart_transmitter_with_fifo_core_macros.svh"
module uarttx_skid
	import uarttx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      out_v_q;
	logic      skid_v_q;
	out_item_t out_q;
	out_item_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign room      = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	`UTX_ASSERT_NEVER(a_skid_alone, skid_v_q && !out_v_q, "skid holds data with output empty")
	`UTX_ASSERT(a_skid_no_push, skid_v_q |-> !push, "transfer accepted while skid full")
	`UTX_ASSERT(a_skid_drains, out_v_q && out_ready && skid_v_q |=> out_v_q && !skid_v_q,
		"skid entry did not move to output")

endmodule

>>> src/uart_transmitter_with_fifo_core.sv
// UART transmitter with transmit FIFO; byte store in uarttx_ram, results via uarttx_skid.
// Depends on uarttx_pkg and the assertion macro header.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------
//  item     | item_valid / item_ready     | item   (in_item_t)
//  result   | result_valid / result_ready | result (out_item_t)
//  config   | cfg_we                      | cfg_index, cfg_data
//
// One item per cycle while item_ready is high, handled in the cycle it is transferred.
// The FIFO head comes from the store's registered read port, addressed with the
// next read pointer and forwarded from a same-cycle write.
// A result stalled at the output goes to a skid entry; item_ready drops only
// while that entry is full. Reset clears pointers, framer and config.
`include "uart_transmitter_with_fifo_core_macros.svh"
module uart_transmitter_with_fifo_core
	import uarttx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  logic [1:0] cfg_data
);

	logic       enable_q;
	logic       parity_frame_q;
	logic       parity_invert_q;
	level_sel_t level_select_q;

	logic [PTR_W-1:0] rptr_q, wptr_q;
	logic [9:0]       shifter_q;
	logic [3:0]       cnt_q;
	logic             sending_q;

	logic [PTR_W-1:0] nxt_rptr, nxt_wptr, nxt_fill, fill;
	logic [9:0]       nxt_shifter;
	logic [3:0]       nxt_cnt;
	logic             nxt_sending;
	logic [7:0]       head;
	logic             acc, wr, load, shift, done, ninth, lvl;
	out_item_t        res;

	assign acc = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			parity_frame_q  <= 1'b0;
			parity_invert_q <= 1'b0;
			level_select_q  <= LVL_EMPTY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:        enable_q        <= cfg_data[0];
				CFG_PARITY_FRAME:  parity_frame_q  <= cfg_data[0];
				CFG_PARITY_INVERT: parity_invert_q <= cfg_data[0];
				CFG_LEVEL_SELECT:  level_select_q  <= level_sel_t'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		fill  = fill_level(wptr_q, rptr_q);
		ninth = parity_frame_q ? ((^head) ^ parity_invert_q) : 1'b1;
		load  = item.baud_tick && (fill != '0) && !sending_q;
		shift = sending_q && item.baud_tick;
		done  = (cnt_q == (parity_frame_q ? END_PARITY : END_PLAIN));
		wr    = item.write_valid && (fill < PTR_W'(FIFO_DEPTH));
		if (!enable_q) begin
			nxt_rptr    = '0;
			nxt_wptr    = '0;
			nxt_shifter = SHIFT_IDLE;
			nxt_cnt     = '0;
			nxt_sending = 1'b0;
		end else begin
			nxt_rptr = load ? ptr_next(rptr_q) : rptr_q;
			nxt_wptr = wr ? ptr_next(wptr_q) : wptr_q;
			if (load) begin
				nxt_shifter = {ninth, head, 1'b0};
			end else if (shift) begin
				nxt_shifter = {1'b1, shifter_q[9:1]};
			end else begin
				nxt_shifter = shifter_q;
			end
			if (done) begin
				nxt_cnt = '0;
			end else if (shift) begin
				nxt_cnt = cnt_q + 4'd1;
			end else begin
				nxt_cnt = cnt_q;
			end
			if (load) begin
				nxt_sending = 1'b1;
			end else if (sending_q && done) begin
				nxt_sending = 1'b0;
			end else begin
				nxt_sending = sending_q;
			end
		end
		nxt_fill           = fill_level(nxt_wptr, nxt_rptr);
		lvl                = level_hit(level_select_q, nxt_fill);
		res.tx_line        = nxt_shifter[0];
		res.busy_res       = !(!nxt_sending && lvl);
		res.not_full       = (nxt_fill < PTR_W'(FIFO_DEPTH));
		res.level_reached  = lvl;
		res.queued_count   = nxt_fill[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q    <= '0;
			wptr_q    <= '0;
			shifter_q <= SHIFT_IDLE;
			cnt_q     <= '0;
			sending_q <= 1'b0;
		end else if (acc) begin
			rptr_q    <= nxt_rptr;
			wptr_q    <= nxt_wptr;
			shifter_q <= nxt_shifter;
			cnt_q     <= nxt_cnt;
			sending_q <= nxt_sending;
		end
	end

	uarttx_ram u_ram (
		.clk   (clk),
		.we    (acc && enable_q && wr),
		.waddr (ptr_index(wptr_q)),
		.wdata (item.write_data),
		.re    (acc),
		.raddr (ptr_index(nxt_rptr)),
		.rdata (head)
	);

	uarttx_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.room      (item_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

	`UTX_ASSERT_NEVER(a_fill_range, fill > PTR_W'(FIFO_DEPTH), "FIFO fill above depth")
	`UTX_ASSERT(a_idle_count, !sending_q |-> cnt_q == '0, "bit counter nonzero while idle")
	`UTX_ASSERT(a_disable_flush, acc && !enable_q |=> rptr_q == '0 && wptr_q == '0,
		"pointers not flushed while disabled")
	`UTX_ASSERT(a_idle_line, acc && !enable_q |=> shifter_q == SHIFT_IDLE && !sending_q,
		"line not idle while disabled")

endmodule

>>> tb/tb.sv
// Self-checking bench for uart_transmitter_with_fifo_core: per-cycle line and FIFO status
// is predicted in-bench and checked against every result transfer.
// Depends on uarttx_pkg and the core RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import uarttx_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_ENABLE;
	logic [1:0] cfg_data = 2'd0;

	uart_transmitter_with_fifo_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	in_item_t  pending_cycles[$];
	out_item_t tx_status_q[$];
	int        mismatches = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	logic      tx_quiet = 1'b0;
	logic      rx_quiet = 1'b0;

	// predicted copy of the transmitter
	logic             pr_en, pr_pframe, pr_pinv;
	level_sel_t       pr_lsel;
	logic [7:0]       pr_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] pr_rd, pr_wr;
	logic [9:0]       pr_frame;
	logic [3:0]       pr_bits;
	logic             pr_sending;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One accepted item of the transmitter; returns the status seen after the update.
	task automatic uart_cycle(input in_item_t it, output out_item_t st);
		logic [PTR_W-1:0] n;
		logic [7:0] head;
		logic ninth, load, shift, done, lvl;
		if (!pr_en) begin
			pr_bits = '0;
			pr_frame = SHIFT_IDLE;
			pr_sending = 1'b0;
			pr_rd = '0;
			pr_wr = '0;
		end else begin
			n = pr_wr - pr_rd;
			head = pr_mem[pr_rd[IDX_W-1:0]];
			ninth = pr_pframe ? (^head ^ pr_pinv) : 1'b1;
			load = it.baud_tick && (n != 0) && !pr_sending;
			shift = pr_sending && it.baud_tick;
			done = (pr_bits == (pr_pframe ? END_PARITY : END_PLAIN));
			if (done) begin
				pr_bits = '0;
			end else if (shift) begin
				pr_bits = pr_bits + 4'd1;
			end
			if (load) begin
				pr_frame = {ninth, head, 1'b0};
			end else if (shift) begin
				pr_frame = {1'b1, pr_frame[9:1]};
			end
			if (!pr_sending && load) begin
				pr_sending = 1'b1;
			end else if (pr_sending && done) begin
				pr_sending = 1'b0;
			end
			if (load) pr_rd = pr_rd + 1'b1;
			// writes land at the old write pointer; a full FIFO drops them
			if (it.write_valid && n < PTR_W'(FIFO_DEPTH)) begin
				pr_mem[pr_wr[IDX_W-1:0]] = it.write_data;
				pr_wr = pr_wr + 1'b1;
			end
		end
		n = pr_wr - pr_rd;
		case (pr_lsel)
			LVL_EMPTY: lvl = (n == 0);
			LVL_TWO:   lvl = (n <= 2);
			LVL_FOUR:  lvl = (n <= 4);
			default:   lvl = (n <= 8);
		endcase
		st.tx_line = pr_frame[0];
		st.busy_res = !(!pr_sending && lvl);
		st.not_full = (n < PTR_W'(FIFO_DEPTH));
		st.level_reached = lvl;
		st.queued_count = 5'(n);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else if (!item_valid || item_ready) begin
			if (send_gap > 0) begin
				item_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_cycles.size() > 0) begin
				item <= pending_cycles.pop_front();
				item_valid <= 1'b1;
				send_gap <= tx_quiet ? 0 : pick_idle();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor: register writes, prediction on item transfer, check on result transfer
	always @(posedge clk or negedge arst_n) begin
		out_item_t predicted;
		out_item_t oldest;
		if (!arst_n) begin
			pr_en = 1'b0;
			pr_pframe = 1'b0;
			pr_pinv = 1'b0;
			pr_lsel = LVL_EMPTY;
			pr_rd = '0;
			pr_wr = '0;
			pr_frame = SHIFT_IDLE;
			pr_bits = '0;
			pr_sending = 1'b0;
			result_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE:        pr_en = cfg_data[0];
					CFG_PARITY_FRAME:  pr_pframe = cfg_data[0];
					CFG_PARITY_INVERT: pr_pinv = cfg_data[0];
					CFG_LEVEL_SELECT:  pr_lsel = level_sel_t'(cfg_data);
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				uart_cycle(item, predicted);
				tx_status_q.push_back(predicted);
			end
			if (result_valid && result_ready) begin
				if (tx_status_q.size() == 0) begin
					$error("result transfer with nothing expected: %h", result);
					mismatches++;
				end else begin
					oldest = tx_status_q.pop_front();
					if (result.tx_line !== oldest.tx_line) begin
						$error("tx_line: expected %0b, got %0b", oldest.tx_line, result.tx_line);
						mismatches++;
					end
					if (result.busy_res !== oldest.busy_res) begin
						$error("busy_res: expected %0b, got %0b", oldest.busy_res,
							result.busy_res);
						mismatches++;
					end
					if (result.not_full !== oldest.not_full) begin
						$error("not_full: expected %0b, got %0b", oldest.not_full,
							result.not_full);
						mismatches++;
					end
					if (result.level_reached !== oldest.level_reached) begin
						$error("level_reached: expected %0b, got %0b", oldest.level_reached,
							result.level_reached);
						mismatches++;
					end
					if (result.queued_count !== oldest.queued_count) begin
						$error("queued_count: expected %0d, got %0d", oldest.queued_count,
							result.queued_count);
						mismatches++;
					end
				end
			end
			if (rx_quiet) begin
				result_ready <= 1'b1;
				stall_left <= 0;
			end else if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				result_ready <= 1'b1;
				stall_left <= pick_idle();
			end
		end
	end

	task automatic queue_cycle(input logic tick, input logic wv, input logic [7:0] data);
		pending_cycles.push_back('{baud_tick: tick, write_valid: wv, write_data: data});
	endtask

	// sampled at the falling edge so that edge updates have settled
	task automatic wait_drained();
		while (pending_cycles.size() != 0 || item_valid || tx_status_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_regs(input logic en, input logic pf, input logic pinv,
			input level_sel_t ls);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ENABLE;
		cfg_data <= {1'b0, en};
		@(posedge clk);
		cfg_index <= CFG_PARITY_FRAME;
		cfg_data <= {1'b0, pf};
		@(posedge clk);
		cfg_index <= CFG_PARITY_INVERT;
		cfg_data <= {1'b0, pinv};
		@(posedge clk);
		cfg_index <= CFG_LEVEL_SELECT;
		cfg_data <= ls;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent_cycles;
		int len;
		int tick_pct;
		int wr_pct;
		logic en;
		sent_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Parity frame: write+tick on an empty FIFO must not load; next tick loads,
		// ten more ticks leave the bit counter at its parity end value.
		program_regs(1'b1, 1'b1, 1'b0, LVL_EMPTY);
		queue_cycle(1'b1, 1'b1, 8'h00);
		queue_cycle(1'b1, 1'b1, 8'hFF);
		repeat (10) queue_cycle(1'b1, 1'b0, 8'h00);

		// Switch to plain frame mid-frame: the counter wraps past 15 before ending.
		program_regs(1'b1, 1'b0, 1'b1, LVL_EIGHT);
		for (int i = 0; i < 16; i++)
			queue_cycle(1'b1, (i % 4) == 0, (i % 8) == 0 ? 8'h01 : 8'h80);

		// Disabled: writes dropped and pointers flushed.
		program_regs(1'b0, 1'b1, 1'b1, LVL_TWO);
		queue_cycle(1'b1, 1'b1, 8'h7E);
		queue_cycle(1'b0, 1'b1, 8'h81);

		while (sent_cycles < 1400) begin
			en = ($urandom_range(0, 7) != 0);
			program_regs(en, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				level_sel_t'($urandom_range(0, 3)));
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			// fill-heavy, mixed and drain-heavy traffic
			case ($urandom_range(0, 2))
				0:       tick_pct = 3;
				1:       tick_pct = 25;
				default: tick_pct = 100;
			endcase
			case ($urandom_range(0, 2))
				0:       wr_pct = 95;
				1:       wr_pct = 50;
				default: wr_pct = 10;
			endcase
			len = $urandom_range(30, 120);
			for (int i = 0; i < len; i++)
				queue_cycle($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < wr_pct,
					8'($urandom_range(0, 255)));
			sent_cycles += len;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/uarttx_pkg.sv
src/uarttx_ram.sv
src/uarttx_skid.sv
src/uart_transmitter_with_fifo_core.sv
tb/tb.sv
